@@ hdl/pfe_pkg.sv @@
`default_nettype none

package pfe_pkg;

    localparam int DATA_W = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_BAD
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_CHAR  = 3'd1,
        STAT_UNDERFLOW = 3'd2,
        STAT_OVERFLOW  = 3'd3,
        STAT_DIV_ZERO  = 3'd4,
        STAT_BAD_COUNT = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_REPORT
    } state_t;

    // classified item handed from the front to the back
    typedef struct packed {
        op_t        op;
        logic [3:0] digit;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

@@ hdl/pfe_ram.sv @@
`default_nettype none

module pfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/pfe_div.sv @@
`default_nettype none

module pfe_div
    import pfe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(DATA_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");
`endif

endmodule

`default_nettype wire

@@ hdl/pfe_front.sv @@
`default_nettype none

module pfe_front
    import pfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] symbol,
    input  logic       last,
    input  logic       req_valid,
    output logic       req_ready,
    output cmd_t       cmd,
    output logic       cmd_valid,
    input  logic       cmd_pop
);

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    cmd_t       item;
    logic       push;

    always_comb
    begin
        item.digit = symbol[3:0];
        item.last  = last;
        unique case (symbol) inside
            [CHAR_ZERO:CHAR_NINE]: item.op = OP_PUSH;
            CHAR_PLUS:             item.op = OP_ADD;
            CHAR_MINUS:            item.op = OP_SUB;
            CHAR_STAR:             item.op = OP_MUL;
            CHAR_SLASH:            item.op = OP_DIV;
            default:               item.op = OP_BAD;
        endcase
    end

    assign req_ready = (fill_reg != 2'd2);
    assign push      = req_valid && req_ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !cmd_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

@@ hdl/pfe_back.sv @@
`default_nettype none

module pfe_back
    import pfe_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    output div_req_t           div_req,
    input  div_rsp_t           div_rsp,
    output logic signed [31:0] value,
    output logic [2:0]         status,
    output logic               rsp_valid,
    input  logic               rsp_ready
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] TWO  = CW'(2);

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    status_t           err_reg, err_next;
    logic [DATA_W-1:0] tos_reg, tos_next;
    op_t               op_reg, op_next;
    logic              last_reg, last_next;
    logic              neg_reg, neg_next;

    logic              ram_we, ram_re;
    logic [DATA_W-1:0] rdata;
    logic [CW-1:0]     count_m1, count_m2;
    logic [DATA_W-1:0] lhs, rhs, lhs_mag, rhs_mag, alu_res, quo_signed;
    logic              head_is_op, head_starts_op;
    status_t           report_stat;

    // top of stack lives in tos_reg; the RAM holds the entries below it
    pfe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_m1[AW-1:0]),
        .wdata (tos_reg),
        .re    (ram_re),
        .raddr (count_m2[AW-1:0]),
        .rdata (rdata)
    );

    assign count_m1 = count_reg - ONE;
    assign count_m2 = count_reg - TWO;

    assign lhs     = rdata;
    assign rhs     = tos_reg;
    assign lhs_mag = lhs[DATA_W-1] ? (DATA_W'(0) - lhs) : lhs;
    assign rhs_mag = rhs[DATA_W-1] ? (DATA_W'(0) - rhs) : rhs;
    assign quo_signed = neg_reg ? (DATA_W'(0) - div_rsp.quotient) : div_rsp.quotient;

    always_comb
    begin
        case (op_reg)
            OP_ADD:  alu_res = lhs + rhs;
            OP_SUB:  alu_res = lhs - rhs;
            default: alu_res = lhs * rhs;
        endcase
    end

    assign head_is_op = (cmd.op == OP_ADD) || (cmd.op == OP_SUB) ||
                        (cmd.op == OP_MUL) || (cmd.op == OP_DIV);
    assign head_starts_op = (err_reg == STAT_OK) && head_is_op && (count_reg >= TWO);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (head_starts_op)
                    begin
                        state_next = ST_EXEC;
                    end
                    else if (cmd.last)
                    begin
                        state_next = ST_REPORT;
                    end
                end
            end
            ST_EXEC:
            begin
                if (op_reg == OP_DIV && rhs != '0)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = last_reg ? ST_REPORT : ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = last_reg ? ST_REPORT : ST_IDLE;
                end
            end
            ST_REPORT:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        count_next       = count_reg;
        err_next         = err_reg;
        tos_next         = tos_reg;
        op_next          = op_reg;
        last_next        = last_reg;
        neg_next         = neg_reg;
        cmd_pop          = 1'b0;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        rsp_valid        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = lhs_mag;
        div_req.divisor  = rhs_mag;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop   = 1'b1;
                    op_next   = cmd.op;
                    last_next = cmd.last;
                    if (err_reg == STAT_OK)
                    begin
                        unique case (cmd.op) inside
                            OP_PUSH:
                            begin
                                if (count_reg == FULL)
                                begin
                                    err_next = STAT_OVERFLOW;
                                end
                                else
                                begin
                                    ram_we     = (count_reg != '0);
                                    tos_next   = {{(DATA_W-4){1'b0}}, cmd.digit};
                                    count_next = count_reg + ONE;
                                end
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                            begin
                                if (count_reg < TWO)
                                begin
                                    err_next = STAT_UNDERFLOW;
                                end
                                else
                                begin
                                    ram_re = 1'b1;
                                end
                            end
                            default: err_next = STAT_BAD_CHAR;
                        endcase
                    end
                end
            end
            ST_EXEC:
            begin
                if (op_reg == OP_DIV)
                begin
                    if (rhs == '0)
                    begin
                        err_next = STAT_DIV_ZERO;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        neg_next      = lhs[DATA_W-1] ^ rhs[DATA_W-1];
                    end
                end
                else
                begin
                    tos_next   = alu_res;
                    count_next = count_m1;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    tos_next   = quo_signed;
                    count_next = count_m1;
                end
            end
            ST_REPORT:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    count_next = '0;
                    err_next   = STAT_OK;
                end
            end
            default: ;
        endcase
    end

    assign report_stat = (err_reg != STAT_OK) ? err_reg :
                         (count_reg != ONE) ? STAT_BAD_COUNT : STAT_OK;
    assign status = report_stat;
    assign value  = (report_stat == STAT_OK) ? tos_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            err_reg   <= STAT_OK;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg  <= tos_next;
        op_reg   <= op_next;
        last_reg <= last_next;
        neg_reg  <= neg_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("stack count beyond depth");

    a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != STAT_OK) |-> (value == '0))
        else $error("nonzero value reported with error status");

    a_clear_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready) |=> (count_reg == '0 && err_reg == STAT_OK))
        else $error("state not cleared after report");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == ST_IDLE && !div_rsp.done))
        else $error("item taken while previous one still running");
`endif

endmodule

`default_nettype wire

@@ hdl/postfix_expression_evaluator.sv @@
`default_nettype none

// Postfix evaluator: one ASCII character per item; digits push, + - * / pop two
// and push the 32-bit result (wrapping, division truncates toward zero). A result
// (value, status) is given only for the item with last set, after which the
// stack and latched error clear. A 2-entry queue sits between the classifying
// front and the executing back, so items are taken while a result waits. Back
// work per item: digits, bad characters, operators that find fewer than two
// entries and items after an error are handled in IDLE; + - * read the stack RAM,
// then use the ALU in EXEC; / reads, starts the one-bit-per-cycle divider in
// EXEC, waits in DIV and writes the quotient back, or stops in EXEC on a zero
// right operand; a last item adds a report state held until the result is taken.
module postfix_expression_evaluator
    import pfe_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         symbol,
    input  logic               last,
    input  logic               req_valid,
    output logic               req_ready,
    output logic signed [31:0] value,
    output logic [2:0]         status,
    output logic               rsp_valid,
    input  logic               rsp_ready
);

    cmd_t     cmd;
    logic     cmd_valid;
    logic     cmd_pop;
    div_req_t div_req;
    div_rsp_t div_rsp;

    pfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .symbol    (symbol),
        .last      (last),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    pfe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pfe_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .value     (value),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

endmodule

`default_nettype wire

@@ verif/postfix_expression_evaluator_tb.sv @@
`timescale 1ns / 1ps

module postfix_expression_evaluator_tb;
    import pfe_pkg::*;

    localparam int STACK_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 950;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [7:0] sym;
        logic       last;
        int         phase;
    } pending_item_t;

    typedef struct {
        logic [31:0] value;
        status_t     status;
    } expr_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic [7:0]         symbol = 8'd0;
    logic               last = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic signed [31:0] value;
    logic [2:0]         status;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;

    pending_item_t pending_symbols[$];
    expr_result_t  expected_results[$];

    // evaluator shadow state
    logic [31:0] pred_stack [STACK_DEPTH];
    int          pred_cnt = 0;
    status_t     pred_err = STAT_OK;

    logic req_taken = 1'b0;
    int   cur_phase = 0;
    int   mismatch_cnt = 0;
    int   quiet_cycles = 0;

    postfix_expression_evaluator #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .symbol   (symbol),
        .last     (last),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .value    (value),
        .status   (status),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready)
    );

    always #10 clk = ~clk;

    function automatic logic [31:0] trunc_div(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? (32'd0 - a) : a;
        mb = b[31] ? (32'd0 - b) : b;
        q  = ma / mb;
        return (a[31] != b[31]) ? (32'd0 - q) : q;
    endfunction

    task automatic eval_symbol(input logic [7:0] sym, input logic is_last);
        logic [31:0]  rhs;
        logic [31:0]  lhs;
        logic [31:0]  res;
        expr_result_t r;
        if (pred_err == STAT_OK)
        begin
            if (sym >= CHAR_ZERO && sym <= CHAR_NINE)
            begin
                if (pred_cnt >= STACK_DEPTH)
                    pred_err = STAT_OVERFLOW;
                else
                begin
                    pred_stack[pred_cnt] = {24'd0, sym - CHAR_ZERO};
                    pred_cnt++;
                end
            end
            else if (sym == CHAR_PLUS || sym == CHAR_MINUS || sym == CHAR_STAR ||
                     sym == CHAR_SLASH)
            begin
                if (pred_cnt < 2)
                    pred_err = STAT_UNDERFLOW;
                else
                begin
                    // right operand is on top
                    rhs = pred_stack[pred_cnt - 1];
                    lhs = pred_stack[pred_cnt - 2];
                    if (sym == CHAR_SLASH && rhs == 32'd0)
                        pred_err = STAT_DIV_ZERO;
                    else
                    begin
                        case (sym)
                            CHAR_PLUS:  res = lhs + rhs;
                            CHAR_MINUS: res = lhs - rhs;
                            CHAR_STAR:  res = lhs * rhs;
                            default:    res = trunc_div(lhs, rhs);
                        endcase
                        pred_cnt--;
                        pred_stack[pred_cnt - 1] = res;
                    end
                end
            end
            else
                pred_err = STAT_BAD_CHAR;
        end
        if (is_last)
        begin
            r.value  = 32'd0;
            r.status = pred_err;
            if (pred_err == STAT_OK)
            begin
                if (pred_cnt != 1)
                    r.status = STAT_BAD_COUNT;
                else
                    r.value = pred_stack[0];
            end
            expected_results.push_back(r);
            pred_cnt = 0;
            pred_err = STAT_OK;
        end
    endtask

    task automatic add_symbol(input logic [7:0] sym, input logic is_last, input int phase);
        pending_item_t it;
        it.sym   = sym;
        it.last  = is_last;
        it.phase = phase;
        pending_symbols.push_back(it);
    endtask

    // one expression given as text; last set on its final character
    task automatic queue_text(input string s, input int phase);
        for (int i = 0; i < s.len(); i++)
            add_symbol(s[i], i == s.len() - 1, phase);
    endtask

    function automatic logic [7:0] digit_char();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] op_char();
        case ($urandom_range(0, 3))
            0:       return CHAR_PLUS;
            1:       return CHAR_MINUS;
            2:       return CHAR_STAR;
            default: return CHAR_SLASH;
        endcase
    endfunction

    task automatic queue_tokens(ref logic [7:0] toks[$], input int phase);
        for (int i = 0; i < toks.size(); i++)
            add_symbol(toks[i], i == toks.size() - 1, phase);
    endtask

    // well-formed expression, now and then broken on purpose
    task automatic gen_expression(input int phase);
        logic [7:0] toks[$];
        int operands;
        int pushed;
        int depth;
        int pos;
        operands = $urandom_range(1, 8);
        pushed   = 0;
        depth    = 0;
        while (pushed < operands || depth > 1)
        begin
            if (pushed < operands && (depth < 2 || $urandom_range(0, 1) == 1))
            begin
                toks.push_back(digit_char());
                pushed++;
                depth++;
            end
            else
            begin
                toks.push_back(op_char());
                depth--;
            end
        end
        pos = $urandom_range(0, toks.size() - 1);
        case ($urandom_range(0, 9))
            0: toks[pos] = 8'($urandom_range(0, 255));
            1: toks.delete(pos);
            2: toks.push_back(digit_char());
            default: ;
        endcase
        queue_tokens(toks, phase);
    endtask

    // push from two below to one past the stack depth, then fold it down
    task automatic gen_deep(input int phase);
        logic [7:0] toks[$];
        int n;
        n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 1);
        for (int i = 0; i < n; i++)
            toks.push_back(digit_char());
        for (int i = 1; i < n; i++)
            toks.push_back(op_char());
        queue_tokens(toks, phase);
    endtask

    // long product chain to exercise wraparound
    task automatic gen_chain(input int phase);
        logic [7:0] toks[$];
        int n;
        if ($urandom_range(0, 1) == 1)
            queue_text("88*8*8*8*8*8*8*8*8*2*01-/", phase);
        else
        begin
            toks.push_back(digit_char());
            n = $urandom_range(3, 12);
            for (int i = 0; i < n; i++)
            begin
                toks.push_back(CHAR_ZERO + 8'($urandom_range(2, 9)));
                toks.push_back(CHAR_STAR);
            end
            if ($urandom_range(0, 1) == 1)
            begin
                toks.push_back(CHAR_ZERO);
                toks.push_back(digit_char());
                toks.push_back(CHAR_MINUS);
                toks.push_back(CHAR_SLASH);
            end
            else
            begin
                toks.push_back(digit_char());
                toks.push_back(op_char());
            end
            queue_tokens(toks, phase);
        end
    endtask

    task automatic gen_noise(input int phase);
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            add_symbol(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), phase);
    endtask

    function automatic int sender_idle_pct(input int phase);
        case (phase)
            0:       return 17;
            1:       return 78;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct(input int phase);
        case (phase)
            0:       return 78;
            1:       return 17;
            default: return 0;
        endcase
    endfunction

    task automatic log_mismatch(input string what, input logic signed [31:0] exp_v,
                                input logic signed [31:0] act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    endtask

    // driver
    always @(negedge clk)
    begin : drive_proc
        pending_item_t it;
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (pending_symbols.size() > 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct(pending_symbols[0].phase))
                begin
                    it = pending_symbols.pop_front();
                    symbol    <= it.sym;
                    last      <= it.last;
                    req_valid <= 1'b1;
                    cur_phase <= it.phase;
                end
                else
                    req_valid <= 1'b0;
            end
            rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct(cur_phase));
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin : monitor_proc
        expr_result_t want;
        req_taken <= req_valid && req_ready;
        if (rst_n)
        begin
            if (req_valid && req_ready)
                eval_symbol(symbol, last);
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                    log_mismatch("unexpected result, value", 32'sd0, value);
                else
                begin
                    want = expected_results.pop_front();
                    if (value !== want.value)
                        log_mismatch("value", want.value, value);
                    if (status !== want.status)
                        log_mismatch("status", {29'd0, want.status}, {29'd0, status});
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog_proc
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : stim_proc
        int directed_n;
        int phase;
        int kind;

        // directed: symbol extremes, - * / and a lone +, operand order, error cases
        add_symbol(8'h00, 1'b1, 0);
        add_symbol(8'hFF, 1'b0, 0);
        add_symbol(CHAR_ZERO + 8'd1, 1'b1, 0);
        queue_text("93-8*", 0);
        queue_text("92/", 0);
        queue_text("07-2/", 0);
        queue_text("+", 0);
        queue_text("40/", 0);
        queue_text("12", 0);
        queue_text("3:4+", 0);
        directed_n = pending_symbols.size();

        // most negative quotient once up front
        queue_text("88*8*8*8*8*8*8*8*8*2*01-/", 0);
        while (pending_symbols.size() < directed_n + RANDOM_ITEMS)
        begin
            phase = (pending_symbols.size() - directed_n) * 3 / RANDOM_ITEMS;
            if (phase > 2)
                phase = 2;
            kind = $urandom_range(0, 99);
            if (kind < 60)
                gen_expression(phase);
            else if (kind < 70)
                gen_deep(phase);
            else if (kind < 80)
                gen_chain(phase);
            else
                gen_noise(phase);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_symbols.size() != 0 || req_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ postfix_expression_evaluator.f @@
hdl/pfe_pkg.sv
hdl/pfe_ram.sv
hdl/pfe_div.sv
hdl/pfe_front.sv
hdl/pfe_back.sv
hdl/postfix_expression_evaluator.sv
verif/postfix_expression_evaluator_tb.sv
